// ===== src/rss_pkg.sv =====
`default_nettype none
package rss_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int CMP_W      = (CNT_W > 4) ? CNT_W : 4;
    localparam int KIND_W     = 2;
    localparam int IN_SLOT_W  = 4;
    localparam int YIELD_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int TAG_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = YIELD_W + CNT_W;
    localparam int TGT_W      = SUM_W + FRAC_W;

    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHOSEN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SDRAIN,
        ST_PROD,
        ST_SUM,
        ST_TARGET,
        ST_WALK,
        ST_WDRAIN,
        ST_FIN
    } state_t;

    // strobes from the sequencer to the arithmetic
    typedef struct packed {
        logic scan_clr;
        logic scan_take;
        logic prod_en;
        logic sum_en;
        logic tgt_en;
        logic cum_clr;
        logic walk_take;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== src/roulette_source_selector.sv =====
// roulette_source_selector: weighted random choice over a table of sources.
//
// Input channel (in_valid/in_ready) takes one word per item: kind selects
// update (write source_slot's yield and mark it valid), remove (clear the
// slot's valid mark) or select (draw a slot using random_fraction). Every
// word yields exactly one result word on the output channel (out_valid/
// out_ready): echo_tag, chosen_slot and status (updated, chosen, none known).
//
// Sequence: update, remove and unused kinds go straight to the result state.
// A select reads the yield memory once per slot to gather min, max, count
// and sum, steps through the product, sum and target states for the weight
// sum and the roll product (only the first when no slot is valid), then reads
// the memory again until the cumulative weight passes the roll or every slot
// is read. The result loads into the output register once that register is
// empty or being drained. The single read port of the yield memory sets both
// walks. One word is in work at a time; in_ready rises the cycle after the
// result loads.
//
// Reset clears all valid marks; yields hold garbage until written. When the
// receiver stalls, the result waits in the output register and the next word
// is taken and worked on; its result waits until the register frees.
`default_nettype none
module roulette_source_selector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [rss_pkg::KIND_W-1:0]        kind,
    input  wire logic [rss_pkg::IN_SLOT_W-1:0]     source_slot,
    input  wire logic [rss_pkg::YIELD_W-1:0]       yield_value,
    input  wire logic [rss_pkg::FRAC_W-1:0]        random_fraction,
    input  wire logic [rss_pkg::TAG_W-1:0]         requester_tag,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [rss_pkg::TAG_W-1:0]         echo_tag,
    output logic      [rss_pkg::IN_SLOT_W-1:0]     chosen_slot,
    output logic      [rss_pkg::STATUS_W-1:0]      status
);

    logic                                wr_en;
    logic [rss_pkg::SLOT_W-1:0]          wr_addr;
    logic                                rd_en;
    logic [rss_pkg::SLOT_W-1:0]          rd_addr;
    logic [rss_pkg::YIELD_W-1:0]         rd_data;
    rss_pkg::ctrl_t                      ctl;
    logic                                any;
    logic                                hit;
    logic                                out_free;
    logic                                res_load;
    logic [rss_pkg::STATUS_W-1:0]        res_status;
    logic [rss_pkg::IN_SLOT_W-1:0]       res_slot;
    logic                                in_accept;

    // words captured at acceptance for use while the select runs
    logic [rss_pkg::FRAC_W-1:0]          frac_reg;
    logic [rss_pkg::TAG_W-1:0]           tag_reg;

    // output register
    logic                                out_valid_reg;
    logic [rss_pkg::TAG_W-1:0]           echo_tag_reg;
    logic [rss_pkg::IN_SLOT_W-1:0]       chosen_slot_reg;
    logic [rss_pkg::STATUS_W-1:0]        status_reg;

    assign in_accept   = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign echo_tag    = echo_tag_reg;
    assign chosen_slot = chosen_slot_reg;
    assign status      = status_reg;

    rss_ram #(
        .WIDTH (rss_pkg::YIELD_W),
        .DEPTH (rss_pkg::SLOTS)
    ) u_yield_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (yield_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rss_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .kind        (kind),
        .source_slot (source_slot),
        .in_ready    (in_ready),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .ctl         (ctl),
        .any         (any),
        .hit         (hit),
        .out_free    (out_free),
        .res_load    (res_load),
        .res_status  (res_status),
        .res_slot    (res_slot)
    );

    rss_datapath u_datapath (
        .clk     (clk),
        .ctl     (ctl),
        .rd_data (rd_data),
        .frac    (frac_reg),
        .any     (any),
        .hit     (hit)
    );

    // hold the roll and the tag for the whole select
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            frac_reg <= random_fraction;
            tag_reg  <= requester_tag;
        end
        if (res_load)
        begin
            echo_tag_reg    <= tag_reg;
            chosen_slot_reg <= res_slot;
            status_reg      <= res_status;
        end
    end

    // load a result when the register is empty or being drained; drop valid
    // once the receiver takes the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== src/rss_ram.sv =====
`default_nettype none
module rss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/rss_datapath.sv =====
`default_nettype none
module rss_datapath (
    input  wire logic                           clk,
    input  wire rss_pkg::ctrl_t                 ctl,
    input  wire logic [rss_pkg::YIELD_W-1:0]    rd_data,
    input  wire logic [rss_pkg::FRAC_W-1:0]     frac,
    output logic                                any,
    output logic                                hit
);

    logic [rss_pkg::CNT_W-1:0]   cnt_reg;
    logic [rss_pkg::YIELD_W-1:0] mn_reg;
    logic [rss_pkg::YIELD_W-1:0] mx_reg;
    logic [rss_pkg::SUM_W-1:0]   sumy_reg;
    logic [rss_pkg::SUM_W-1:0]   prod_reg;
    logic                        flat_reg;
    logic [rss_pkg::SUM_W-1:0]   sum_reg;
    logic [rss_pkg::TGT_W-1:0]   target_reg;
    logic [rss_pkg::SUM_W-1:0]   cum_reg;
    logic [rss_pkg::SUM_W-1:0]   weight;
    logic [rss_pkg::SUM_W-1:0]   cum_next;

    // weight numerator: yield above minimum, or one when all yields match
    assign weight   = flat_reg ? rss_pkg::SUM_W'(1)
                               : rss_pkg::SUM_W'(rd_data - mn_reg);
    assign cum_next = cum_reg + weight;
    assign any      = (cnt_reg != '0);
    assign hit      = ctl.walk_take
                      && ({cum_next, rss_pkg::FRAC_W'(0)} > target_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.scan_clr)
        begin
            cnt_reg  <= '0;
            sumy_reg <= '0;
        end
        else if (ctl.scan_take)
        begin
            if ((cnt_reg == '0) || (rd_data < mn_reg))
            begin
                mn_reg <= rd_data;
            end
            if ((cnt_reg == '0) || (rd_data > mx_reg))
            begin
                mx_reg <= rd_data;
            end
            sumy_reg <= sumy_reg + rss_pkg::SUM_W'(rd_data);
            cnt_reg  <= cnt_reg + rss_pkg::CNT_W'(1);
        end

        if (ctl.prod_en)
        begin
            prod_reg <= rss_pkg::SUM_W'(cnt_reg) * rss_pkg::SUM_W'(mn_reg);
            flat_reg <= (mx_reg == mn_reg);
        end

        // sum of (yield - min) is sum of yields less count times min
        if (ctl.sum_en)
        begin
            sum_reg <= flat_reg ? rss_pkg::SUM_W'(cnt_reg) : (sumy_reg - prod_reg);
        end

        if (ctl.tgt_en)
        begin
            target_reg <= rss_pkg::TGT_W'(frac) * rss_pkg::TGT_W'(sum_reg);
        end

        if (ctl.cum_clr)
        begin
            cum_reg <= '0;
        end
        else if (ctl.walk_take)
        begin
            cum_reg <= cum_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/rss_ctrl.sv =====
`default_nettype none
module rss_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic [rss_pkg::KIND_W-1:0]      kind,
    input  wire logic [rss_pkg::IN_SLOT_W-1:0]   source_slot,
    output logic                                 in_ready,
    output logic                                 wr_en,
    output logic      [rss_pkg::SLOT_W-1:0]      wr_addr,
    output logic                                 rd_en,
    output logic      [rss_pkg::SLOT_W-1:0]      rd_addr,
    output rss_pkg::ctrl_t                       ctl,
    input  wire logic                            any,
    input  wire logic                            hit,
    input  wire logic                            out_free,
    output logic                                 res_load,
    output logic      [rss_pkg::STATUS_W-1:0]    res_status,
    output logic      [rss_pkg::IN_SLOT_W-1:0]   res_slot
);

    rss_pkg::state_t                    state_reg;
    rss_pkg::state_t                    state_next;
    logic [rss_pkg::SLOT_W-1:0]         idx_reg;
    logic [rss_pkg::SLOT_W-1:0]         pidx_reg;
    logic                               dv_reg;
    logic                               pv_reg;
    logic [rss_pkg::SLOTS-1:0]          valid_reg;
    logic [rss_pkg::STATUS_W-1:0]       res_status_reg;
    logic [rss_pkg::IN_SLOT_W-1:0]      res_slot_reg;
    logic                               accept;
    logic [rss_pkg::CMP_W-1:0]          slot_wide;
    logic [rss_pkg::CMP_W-1:0]          pidx_wide;
    logic                               in_range;
    logic [rss_pkg::SLOT_W-1:0]         slot_idx;
    logic                               issuing;
    logic                               last_idx;

    assign accept    = in_valid && (state_reg == rss_pkg::ST_IDLE);
    assign slot_wide = rss_pkg::CMP_W'(source_slot);
    assign in_range  = slot_wide < rss_pkg::CMP_W'(rss_pkg::SLOTS);
    assign slot_idx  = slot_wide[rss_pkg::SLOT_W-1:0];
    assign pidx_wide = rss_pkg::CMP_W'(pidx_reg);
    assign issuing   = (state_reg == rss_pkg::ST_SCAN) || (state_reg == rss_pkg::ST_WALK);
    assign last_idx  = (idx_reg == rss_pkg::SLOT_W'(rss_pkg::SLOTS - 1));
    assign res_status = res_status_reg;
    assign res_slot   = res_slot_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (kind == rss_pkg::KIND_SELECT) ? rss_pkg::ST_SCAN
                                                                : rss_pkg::ST_FIN;
                end
            end
            rss_pkg::ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = rss_pkg::ST_SDRAIN;
                end
            end
            rss_pkg::ST_SDRAIN: state_next = rss_pkg::ST_PROD;
            rss_pkg::ST_PROD:   state_next = any ? rss_pkg::ST_SUM : rss_pkg::ST_FIN;
            rss_pkg::ST_SUM:    state_next = rss_pkg::ST_TARGET;
            rss_pkg::ST_TARGET: state_next = rss_pkg::ST_WALK;
            rss_pkg::ST_WALK:
            begin
                if (hit)
                begin
                    state_next = rss_pkg::ST_FIN;
                end
                else if (last_idx)
                begin
                    state_next = rss_pkg::ST_WDRAIN;
                end
            end
            rss_pkg::ST_WDRAIN: state_next = rss_pkg::ST_FIN;
            rss_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = rss_pkg::ST_IDLE;
                end
            end
            default:            state_next = rss_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == rss_pkg::ST_IDLE);
        wr_en         = accept && (kind == rss_pkg::KIND_UPDATE) && in_range;
        wr_addr       = slot_idx;
        rd_en         = issuing;
        rd_addr       = idx_reg;
        ctl.scan_clr  = accept;
        ctl.scan_take = dv_reg && pv_reg
                        && ((state_reg == rss_pkg::ST_SCAN)
                            || (state_reg == rss_pkg::ST_SDRAIN));
        ctl.prod_en   = (state_reg == rss_pkg::ST_PROD);
        ctl.sum_en    = (state_reg == rss_pkg::ST_SUM);
        ctl.tgt_en    = (state_reg == rss_pkg::ST_TARGET);
        ctl.cum_clr   = (state_reg == rss_pkg::ST_TARGET);
        ctl.walk_take = dv_reg && pv_reg
                        && ((state_reg == rss_pkg::ST_WALK)
                            || (state_reg == rss_pkg::ST_WDRAIN));
        res_load      = (state_reg == rss_pkg::ST_FIN) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rss_pkg::ST_IDLE;
            idx_reg        <= '0;
            pidx_reg       <= '0;
            dv_reg         <= 1'b0;
            pv_reg         <= 1'b0;
            valid_reg      <= '0;
            res_status_reg <= rss_pkg::STATUS_UPDATED;
            res_slot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= (issuing && !last_idx) ? idx_reg + rss_pkg::SLOT_W'(1) : '0;
            pidx_reg  <= idx_reg;
            dv_reg    <= issuing;
            pv_reg    <= valid_reg[idx_reg];

            if (accept && in_range && (kind == rss_pkg::KIND_UPDATE))
            begin
                valid_reg[slot_idx] <= 1'b1;
            end
            else if (accept && in_range && (kind == rss_pkg::KIND_REMOVE))
            begin
                valid_reg[slot_idx] <= 1'b0;
            end

            if (accept)
            begin
                res_status_reg <= rss_pkg::STATUS_UPDATED;
                res_slot_reg   <= '0;
            end
            else if ((state_reg == rss_pkg::ST_PROD) && !any)
            begin
                res_status_reg <= rss_pkg::STATUS_NONE;
                res_slot_reg   <= '0;
            end
            else if (hit)
            begin
                res_status_reg <= rss_pkg::STATUS_CHOSEN;
                res_slot_reg   <= pidx_wide[rss_pkg::IN_SLOT_W-1:0];
            end
            else if (state_reg == rss_pkg::ST_WDRAIN)
            begin
                res_status_reg <= rss_pkg::STATUS_NONE;
                res_slot_reg   <= '0;
            end
        end
    end

    a_hit_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (state_reg == rss_pkg::ST_FIN)
                && (res_status_reg == rss_pkg::STATUS_CHOSEN))
        else $error("walk hit did not close the select");

    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rss_pkg::ST_SCAN) && last_idx |=> (state_reg == rss_pkg::ST_SDRAIN))
        else $error("scan did not stop after the last slot");

    a_plain_word_fast: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind != rss_pkg::KIND_SELECT) |=> (state_reg == rss_pkg::ST_FIN)
            && (res_status_reg == rss_pkg::STATUS_UPDATED))
        else $error("table word did not go straight to result");

    a_update_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(wr_addr)])
        else $error("update left its slot invalid");

    a_no_take_outside_select: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.scan_take || ctl.walk_take) |-> !in_ready && !wr_en)
        else $error("slot consumed while idle");

endmodule
`default_nettype wire

// ===== tb/roulette_source_selector_tb.sv =====
`timescale 1ns / 1ps

module roulette_source_selector_tb;

    // Kind code with no operation behind it; the block must answer it as a no-op.
    localparam logic [rss_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int TOTAL_WORDS   = 1700;  // directed plus random words
    localparam int TAIL_WORDS    = 120;   // last stretch runs with no idling at all
    localparam int PAUSE_AT      = 900;   // sender drains the block before this word
    localparam int HOLD_AT       = 500;   // results seen before the long receiver hold
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;

    // One input word as the sender offers it.
    typedef struct {
        bit [rss_pkg::KIND_W-1:0]    kind;
        bit [rss_pkg::IN_SLOT_W-1:0] slot;
        bit [rss_pkg::YIELD_W-1:0]   yv;
        bit [rss_pkg::FRAC_W-1:0]    frac;
        bit [rss_pkg::TAG_W-1:0]     tag;
        bit                          drain_first;  // wait for every result before offering
    } word_t;

    // One result word as the block should return it.
    typedef struct {
        bit [rss_pkg::TAG_W-1:0]     tag;
        bit [rss_pkg::IN_SLOT_W-1:0] slot;
        bit [rss_pkg::STATUS_W-1:0]  status;
    } outcome_t;

    // Block inputs start at known values.
    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          in_valid        = 1'b0;
    logic [rss_pkg::KIND_W-1:0]    kind            = '0;
    logic [rss_pkg::IN_SLOT_W-1:0] source_slot     = '0;
    logic [rss_pkg::YIELD_W-1:0]   yield_value     = '0;
    logic [rss_pkg::FRAC_W-1:0]    random_fraction = '0;
    logic [rss_pkg::TAG_W-1:0]     requester_tag   = '0;
    logic                          out_ready       = 1'b0;

    logic                          in_ready;
    logic                          out_valid;
    logic [rss_pkg::TAG_W-1:0]     echo_tag;
    logic [rss_pkg::IN_SLOT_W-1:0] chosen_slot;
    logic [rss_pkg::STATUS_W-1:0]  status;

    // Shadow copy of the source table, advanced once per accepted word.
    bit [rss_pkg::YIELD_W-1:0] yield_tbl [rss_pkg::SLOTS];
    bit                        live_tbl  [rss_pkg::SLOTS];

    word_t    word_queue[$];       // words not yet offered
    outcome_t pending_results[$];  // predicted results, oldest first
    word_t    cur;                 // word currently on the input ports

    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int words_taken  = 0;          // counted by the driver
    int results_seen = 0;          // counted by the monitor, updated at the edge
    int err_cnt      = 0;
    bit quiet_tail   = 1'b0;       // no idling on either side from here on

    roulette_source_selector u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .source_slot     (source_slot),
        .yield_value     (yield_value),
        .random_fraction (random_fraction),
        .requester_tag   (requester_tag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .echo_tag        (echo_tag),
        .chosen_slot     (chosen_slot),
        .status          (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one word to the shadow table and return the result it must produce.
    // A select weighs each live source by yield - min (or 1 when all yields
    // match) and takes the first source whose running weight, scaled by 2^16,
    // passes fraction * total weight. The compare is exact in 64 bits.
    function automatic outcome_t apply_word(input word_t w);
        outcome_t        o;
        bit              any;
        bit              hit;
        int unsigned     lo;
        int unsigned     hi;
        longint unsigned total;
        longint unsigned run;
        longint unsigned roll;
        o.tag    = w.tag;
        o.slot   = '0;
        o.status = rss_pkg::STATUS_UPDATED;
        any      = 1'b0;
        hit      = 1'b0;
        lo       = 0;
        hi       = 0;
        total    = 0;
        run      = 0;
        case (w.kind)
            rss_pkg::KIND_UPDATE:
            begin
                if (int'(w.slot) < rss_pkg::SLOTS)
                begin
                    yield_tbl[w.slot] = w.yv;
                    live_tbl[w.slot]  = 1'b1;
                end
            end
            rss_pkg::KIND_REMOVE:
            begin
                if (int'(w.slot) < rss_pkg::SLOTS)
                    live_tbl[w.slot] = 1'b0;
            end
            rss_pkg::KIND_SELECT:
            begin
                for (int i = 0; i < rss_pkg::SLOTS; i++)
                begin
                    if (live_tbl[i])
                    begin
                        if (!any || yield_tbl[i] < lo)
                            lo = yield_tbl[i];
                        if (!any || yield_tbl[i] > hi)
                            hi = yield_tbl[i];
                        any = 1'b1;
                    end
                end
                if (!any)
                    o.status = rss_pkg::STATUS_NONE;
                else
                begin
                    for (int i = 0; i < rss_pkg::SLOTS; i++)
                    begin
                        if (live_tbl[i])
                            total += (hi == lo) ? 1 : yield_tbl[i] - lo;
                    end
                    roll     = 64'(w.frac) * total;
                    o.status = rss_pkg::STATUS_NONE;
                    for (int i = 0; i < rss_pkg::SLOTS; i++)
                    begin
                        if (live_tbl[i] && !hit)
                        begin
                            run += (hi == lo) ? 1 : yield_tbl[i] - lo;
                            if ((run << 16) > roll)
                            begin
                                hit      = 1'b1;
                                o.slot   = rss_pkg::IN_SLOT_W'(i);
                                o.status = rss_pkg::STATUS_CHOSEN;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic push_word(input bit [rss_pkg::KIND_W-1:0] k, input int s, input int y,
                             input int f, input int t);
        word_t w;
        w.kind        = k;
        w.slot        = rss_pkg::IN_SLOT_W'(s);
        w.yv          = rss_pkg::YIELD_W'(y);
        w.frac        = rss_pkg::FRAC_W'(f);
        w.tag         = rss_pkg::TAG_W'(t);
        w.drain_first = 1'b0;
        word_queue.insert(word_queue.size(), w);
    endtask

    // Yield styles: spread over the full range, a few corner values, all equal,
    // or a narrow band (small weights, frequent ties at the minimum).
    function automatic int draw_yield(input int style, input int base);
        int corner [4] = '{0, 1, 32768, 65535};
        case (style)
            0:       return $urandom_range(0, 65535);
            1:       return corner[$urandom_range(0, 3)];
            2:       return base;
            default: return (base + $urandom_range(0, 3)) & 16'hFFFF;
        endcase
    endfunction

    // Push the roll to both ends now and then; otherwise keep it uniform.
    function automatic int draw_frac();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 65535;
        return $urandom_range(0, 65535);
    endfunction

    // Driver: offer words from word_queue and predict each one the block takes.
    // A held word keeps valid and payload steady until the handshake fires.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            quiet_tail <= 1'b0;
            gap_left   = 0;
            words_taken = 0;
        end
        else
        begin
            // retire the word the block just took
            if (in_valid && in_ready)
            begin
                pending_results.insert(pending_results.size(), apply_word(cur));
                words_taken++;
            end
            // the port is free: idle, wait for a drain, or load the next word
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() == 0 ||
                         (word_queue[0].drain_first && results_seen != words_taken))
                    in_valid <= 1'b0;
                else if (!quiet_tail && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(1, 11) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur = word_queue.pop_front();
                    kind            <= cur.kind;
                    source_slot     <= cur.slot;
                    yield_value     <= cur.yv;
                    random_fraction <= cur.frac;
                    requester_tag   <= cur.tag;
                    in_valid        <= 1'b1;
                end
            end
            quiet_tail <= (word_queue.size() <= TAIL_WORDS);
        end
    end

    // Monitor: check each result word against the oldest prediction, and
    // drive out_ready with random stalls plus one long hold that backs the
    // block up until it refuses input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            results_seen <= 0;
            stall_left   = 0;
            hold_left    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no prediction waiting: echo_tag %0d status %0d",
                           echo_tag, status);
                    err_cnt++;
                end
                else
                begin
                    outcome_t e;
                    e = pending_results.pop_front();
                    if (echo_tag !== e.tag)
                    begin
                        $error("echo_tag: expected %0d, actual %0d", e.tag, echo_tag);
                        err_cnt++;
                    end
                    if (chosen_slot !== e.slot)
                    begin
                        $error("chosen_slot: expected %0d, actual %0d", e.slot, chosen_slot);
                        err_cnt++;
                    end
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, status);
                        err_cnt++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            // start the long hold once, well into the run
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Build the stimulus, release reset, then wait for the block to drain.
    initial
    begin
        int style;
        int base;
        int pick;
        int slot_top;
        int cycle_cnt;
        bit timed_out;

        // directed: empty table, unused kind, remove of a dead slot, a single
        // source (all yields equal), yield and roll extremes, overwrite of a
        // live slot, ties across several slots, then back to empty
        push_word(rss_pkg::KIND_SELECT, 0, 0, 0, 0);
        push_word(KIND_UNUSED, 0, 0, 0, 255);
        push_word(rss_pkg::KIND_REMOVE, 5, 0, 0, 1);
        push_word(rss_pkg::KIND_UPDATE, 0, 0, 0, 2);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 0, 3);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 65535, 4);
        push_word(rss_pkg::KIND_UPDATE, 15, 65535, 0, 5);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 0, 6);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 65535, 7);
        push_word(rss_pkg::KIND_UPDATE, 7, 32768, 0, 8);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 32768, 9);
        push_word(rss_pkg::KIND_UPDATE, 0, 65535, 0, 10);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 12345, 11);
        push_word(rss_pkg::KIND_UPDATE, 7, 65535, 0, 12);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 0, 13);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 65535, 14);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 21845, 15);
        push_word(rss_pkg::KIND_REMOVE, 0, 0, 0, 16);
        push_word(rss_pkg::KIND_REMOVE, 7, 0, 0, 17);
        push_word(rss_pkg::KIND_REMOVE, 15, 0, 0, 18);
        push_word(rss_pkg::KIND_SELECT, 15, 65535, 65535, 19);
        push_word(rss_pkg::KIND_UPDATE, 10, 16'hAAAA, 16'h5555, 20);
        push_word(rss_pkg::KIND_UPDATE, 5, 16'h5555, 16'hAAAA, 21);
        push_word(rss_pkg::KIND_SELECT, 0, 0, 16'h8000, 8'hA5);
        push_word(KIND_UNUSED, 15, 65535, 65535, 8'h5A);

        // random: episodes that fill part of the table and draw from it, with
        // occasional full clears and bursts of noise
        while (word_queue.size() < TOTAL_WORDS)
        begin
            pick     = $urandom_range(0, 9);
            style    = $urandom_range(0, 3);
            base     = $urandom_range(0, 65535);
            slot_top = ($urandom_range(0, 2) == 0) ? 3 : 15;
            if (pick == 0)
            begin
                // empty the table, draw from nothing, then from one source
                for (int s = 0; s < 16; s++)
                    push_word(rss_pkg::KIND_REMOVE, s, $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 255));
                push_word(rss_pkg::KIND_SELECT, $urandom_range(0, 15), 0, draw_frac(),
                          $urandom_range(0, 255));
                push_word(rss_pkg::KIND_UPDATE, $urandom_range(0, 15),
                          draw_yield(style, base),
                          $urandom_range(0, 65535), $urandom_range(0, 255));
                push_word(rss_pkg::KIND_SELECT, 0, 0, draw_frac(), $urandom_range(0, 255));
            end
            else if (pick == 1)
            begin
                // noise: any kind, any field
                repeat ($urandom_range(1, 4))
                    push_word(rss_pkg::KIND_W'($urandom_range(0, 3)),
                              $urandom_range(0, 15),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 255));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_word(rss_pkg::KIND_UPDATE, $urandom_range(0, slot_top),
                              draw_yield(style, base), $urandom_range(0, 65535),
                              $urandom_range(0, 255));
                repeat ($urandom_range(2, 6))
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_word(rss_pkg::KIND_REMOVE, $urandom_range(0, slot_top),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 255));
                    push_word(rss_pkg::KIND_SELECT, $urandom_range(0, 15),
                              $urandom_range(0, 65535), draw_frac(),
                              $urandom_range(0, 255));
                end
            end
        end
        word_queue[PAUSE_AT].drain_first = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge, clear of the clocked processes
        cycle_cnt = 0;
        timed_out = 1'b0;
        while (!(word_queue.size() == 0 && !in_valid && results_seen == words_taken)
               && !timed_out)
        begin
            @(negedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT)
                timed_out = 1'b1;
        end
        // hold a little longer so a stray extra result gets caught
        if (!timed_out)
            repeat (SETTLE_CYCLES) @(negedge clk);

        if (!timed_out && err_cnt == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
